// ----- rtl/el2sr_pkg.sv -----
// el2sr_pkg: shared types, constants and decode functions for the el2 shadow register block
// no dependencies; used by rtl/el2_sysreg_shadow_redirect.sv
package el2sr_pkg;

    // slot layout: pure-shadow registers first, then the e2h-aliased ones
    localparam int NUM_PURE    = 19;
    localparam int NUM_ALIAS   = 14;
    localparam int NUM_SLOTS   = NUM_PURE + NUM_ALIAS;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    // hcr_el2 lives outside the slot array, so the array is one entry shorter
    localparam int FILE_DEPTH  = NUM_SLOTS - 1;
    localparam int FILE_IDX_W  = $clog2(FILE_DEPTH);
    localparam int HCR_SLOT    = 2;
    localparam int HCR_E2H_BIT = 34;
    localparam int HCR_TGE_BIT = 27;

    localparam int DATA_W = 64;
    localparam int ID_W   = 16;

    localparam logic [DATA_W-1:0] MASK_ALL   = '1;
    localparam logic [DATA_W-1:0] MASK_LOW3  = DATA_W'((65'd1 << 3) - 65'd1);
    localparam logic [DATA_W-1:0] MASK_LOW16 = DATA_W'((65'd1 << 16) - 65'd1);
    localparam logic [DATA_W-1:0] MASK_LOW28 = DATA_W'((65'd1 << 28) - 65'd1);
    localparam logic [DATA_W-1:0] MASK_LOW32 = DATA_W'((65'd1 << 32) - 65'd1);

    typedef enum logic [1:0]
    {
        ACT_HANDLED   = 2'd0,
        ACT_REDIRECT  = 2'd1,
        ACT_UNHANDLED = 2'd2
    } action_t;

    typedef struct packed
    {
        logic              hit;
        logic              is_alias;
        logic [SLOT_W-1:0] slot;
    } decode_t;

    // pack op0, op1, crn, crm, op2 into the 16-bit register id
    function automatic logic [ID_W-1:0] sr_id(input int op0, input int op1, input int crn,
                                              input int crm, input int op2);
        return ID_W'((op0 << 14) | (op1 << 11) | (crn << 7) | (crm << 3) | op2);
    endfunction

    localparam logic [ID_W-1:0] SLOT_ID [NUM_SLOTS] = '{
        // pure-shadow registers
        sr_id(3, 4, 0, 0, 0),  sr_id(3, 4, 0, 0, 5),  sr_id(3, 4, 1, 1, 0),
        sr_id(3, 4, 1, 1, 1),  sr_id(3, 4, 1, 1, 3),  sr_id(3, 4, 1, 1, 7),
        sr_id(3, 4, 2, 1, 0),  sr_id(3, 4, 2, 1, 2),  sr_id(3, 4, 13, 0, 2),
        sr_id(3, 4, 14, 0, 3), sr_id(3, 4, 4, 0, 1),  sr_id(3, 4, 4, 0, 0),
        sr_id(3, 4, 6, 0, 4),  sr_id(3, 4, 14, 2, 1), sr_id(3, 4, 14, 2, 2),
        sr_id(3, 4, 14, 2, 0), sr_id(3, 4, 14, 3, 1), sr_id(3, 4, 14, 3, 2),
        sr_id(3, 4, 14, 3, 0),
        // e2h-aliased registers
        sr_id(3, 4, 1, 0, 0),  sr_id(3, 4, 1, 1, 2),  sr_id(3, 4, 2, 0, 0),
        sr_id(3, 4, 2, 0, 1),  sr_id(3, 4, 2, 0, 2),  sr_id(3, 4, 5, 1, 0),
        sr_id(3, 4, 5, 1, 1),  sr_id(3, 4, 5, 2, 0),  sr_id(3, 4, 6, 0, 0),
        sr_id(3, 4, 10, 2, 0), sr_id(3, 4, 10, 3, 0), sr_id(3, 4, 12, 0, 0),
        sr_id(3, 4, 13, 0, 1), sr_id(3, 4, 14, 1, 0)
    };

    // the architectural feature trap register's el1 twin sits at crm 0, not crm 1
    localparam logic [ID_W-1:0] TRAP_CTL_ID    = sr_id(3, 4, 1, 1, 2);
    localparam logic [ID_W-1:0] TRAP_CTL_TWIN  = sr_id(3, 0, 1, 0, 2);

    // match the id against every slot; ids are unique so at most one hits
    function automatic decode_t decode_id(input logic [ID_W-1:0] id);
        decode_t d;
        d = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!d.hit && SLOT_ID[i] == id)
            begin
                d.hit      = 1'b1;
                d.is_alias = (i >= NUM_PURE);
                d.slot     = SLOT_W'(i);
            end
        end
        return d;
    endfunction

    // writable bits per slot; aliased registers are written in full
    function automatic logic [DATA_W-1:0] slot_mask(input logic [SLOT_W-1:0] slot);
        logic [DATA_W-1:0] m;
        case (slot)
            SLOT_W'(3):  m = MASK_LOW28;
            SLOT_W'(4):  m = MASK_LOW16;
            SLOT_W'(7):  m = MASK_LOW32;
            SLOT_W'(11): m = MASK_LOW32;
            SLOT_W'(13): m = MASK_LOW3;
            SLOT_W'(15): m = MASK_LOW32;
            SLOT_W'(16): m = MASK_LOW3;
            SLOT_W'(18): m = MASK_LOW32;
            default:     m = MASK_ALL;
        endcase
        return m;
    endfunction

    // el1 twin of an aliased el2 register: same id with op1 cleared,
    // except the feature trap register whose twin also has crm cleared
    function automatic logic [ID_W-1:0] el1_twin(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] t;
        t = {id[15:14], 3'b000, id[10:0]};
        if (id == TRAP_CTL_ID)
        begin
            t = TRAP_CTL_TWIN;
        end
        return t;
    endfunction

endpackage

// ----- rtl/el2_sysreg_shadow_redirect.sv -----
// el2_sysreg_shadow_redirect: el2 system register shadow file with e2h/tge redirection
// depends on rtl/el2sr_pkg.sv
//
// Takes one system register read or write per beat and returns one result per beat. An access
// is held in an input register, decoded against the constant register table and applied to the
// shadow file, and its result lands in an output register: one access per clock sustained
// while out_stall is low. With hcr_el2.e2h or hcr_el2.tge set, an access to an aliased el2
// register returns a redirect to its el1 twin instead of touching its slot; a write to hcr_el2
// takes effect from the following access. All slots read as zero after reset; unknown ids
// report unhandled and change nothing.
module el2_sysreg_shadow_redirect
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [15:0] sysreg_id,
    input  logic [63:0] write_data,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [63:0] read_data,
    output logic [15:0] redirect_id
);

    logic                                s1_valid_reg;
    logic                                s1_op_reg;
    logic [el2sr_pkg::ID_W-1:0]          s1_id_reg;
    logic [el2sr_pkg::DATA_W-1:0]        s1_data_reg;

    logic [el2sr_pkg::DATA_W-1:0]        hcr_reg;
    logic [el2sr_pkg::DATA_W-1:0]        file_reg [el2sr_pkg::FILE_DEPTH];

    logic                                out_valid_reg;
    el2sr_pkg::action_t                  action_reg;
    logic [el2sr_pkg::DATA_W-1:0]        read_data_reg;
    logic [el2sr_pkg::ID_W-1:0]          redirect_id_reg;

    logic                                s1_advance;
    logic                                in_accept;
    el2sr_pkg::decode_t                  dec;
    logic                                redirect_en;
    logic                                is_hcr;
    logic [el2sr_pkg::FILE_IDX_W-1:0]    file_idx;
    logic [el2sr_pkg::DATA_W-1:0]        slot_rd;
    logic                                slot_access;
    logic                                slot_write;
    el2sr_pkg::action_t                  action_next;
    logic [el2sr_pkg::DATA_W-1:0]        read_data_next;
    logic [el2sr_pkg::ID_W-1:0]          redirect_id_next;
    logic [el2sr_pkg::DATA_W-1:0]        wr_value;

    // handshake: the input stage moves on whenever the result register is free or draining
    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= op;
            s1_id_reg   <= sysreg_id;
            s1_data_reg <= write_data;
        end
    end

    // decode and slot select
    always_comb
    begin
        dec         = el2sr_pkg::decode_id(s1_id_reg);
        redirect_en = hcr_reg[el2sr_pkg::HCR_E2H_BIT] || hcr_reg[el2sr_pkg::HCR_TGE_BIT];
        is_hcr      = (dec.slot == el2sr_pkg::SLOT_W'(el2sr_pkg::HCR_SLOT));
        if (dec.slot > el2sr_pkg::SLOT_W'(el2sr_pkg::HCR_SLOT))
        begin
            file_idx = el2sr_pkg::FILE_IDX_W'(dec.slot - el2sr_pkg::SLOT_W'(1));
        end
        else
        begin
            file_idx = el2sr_pkg::FILE_IDX_W'(dec.slot);
        end
        slot_rd     = is_hcr ? hcr_reg : file_reg[file_idx];
        slot_access = dec.hit && !(dec.is_alias && redirect_en);
        slot_write  = s1_valid_reg && s1_advance && slot_access && s1_op_reg;
        wr_value    = s1_data_reg & el2sr_pkg::slot_mask(dec.slot);
    end

    // result selection
    always_comb
    begin
        action_next      = el2sr_pkg::ACT_UNHANDLED;
        read_data_next   = '0;
        redirect_id_next = '0;
        if (slot_access)
        begin
            action_next = el2sr_pkg::ACT_HANDLED;
            if (!s1_op_reg)
            begin
                read_data_next = slot_rd;
            end
        end
        else if (dec.hit)
        begin
            action_next      = el2sr_pkg::ACT_REDIRECT;
            redirect_id_next = el2sr_pkg::el1_twin(s1_id_reg);
        end
    end

    // shadow file, hcr_el2 kept apart so its control bits read at a fixed place
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcr_reg <= '0;
            for (int i = 0; i < el2sr_pkg::FILE_DEPTH; i++)
            begin
                file_reg[i] <= '0;
            end
        end
        else if (slot_write)
        begin
            if (is_hcr)
            begin
                hcr_reg <= wr_value;
            end
            else
            begin
                file_reg[file_idx] <= wr_value;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            action_reg      <= action_next;
            read_data_reg   <= read_data_next;
            redirect_id_reg <= redirect_id_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = action_reg;
    assign read_data   = read_data_reg;
    assign redirect_id = redirect_id_reg;

endmodule
